// ===== hdl/dss_pkg.sv =====
// shared definitions for the two-stack shared memory block
package dss_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_DUMP = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic               which_stack;
        logic signed [31:0] push_value;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic               last;
    } out_t;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic       push_wr;
        logic       load_stat;
        logic [1:0] stat;
        logic       pop_start;
        logic       dump_start;
        logic       load_data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic lower_empty;
        logic upper_empty;
        logic out_free;
        logic emit_last;
    } sts_t;

endpackage

// ===== hdl/dual_stack_shared_array_top.sv =====
// top level: two stacks sharing one memory, controller plus datapath
// results: push or failed op registers its result in the cycle after acceptance;
// pop reads memory into rdata_reg, then loads the element into the result register
// throughput: one push per cycle unless the output stalls; pop or dump takes no new
// request until done; dump: one element per cycle (single read port) unless stalled
// reset: synchronous active-low aresetn empties both stacks, memory not cleared
module dual_stack_shared_array_top
    import dss_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    cmd_t cmd;
    sts_t sts;

    dss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_data  (s_data),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dss_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

// ===== hdl/dss_ctrl.sv =====
// controller state machine for the two-stack shared memory block
module dss_ctrl
    import dss_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    input  in_t    s_data,
    output logic   s_ready,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg, state_next;
    logic   sel_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign sel_empty = s_data.which_stack ? sts.upper_empty : sts.lower_empty;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                s_ready = sts.out_free;
                if (s_valid && sts.out_free) begin
                    case (s_data.operation)
                        OP_PUSH: begin
                            cmd.load_stat = 1'b1;
                            if (sts.full) begin
                                cmd.stat = STAT_OVERFLOW;
                            end else begin
                                cmd.stat    = STAT_OK;
                                cmd.push_wr = 1'b1;
                            end
                        end
                        OP_POP, OP_DUMP: begin
                            if (sel_empty) begin
                                cmd.load_stat = 1'b1;
                                cmd.stat      = STAT_EMPTY;
                            end else begin
                                cmd.pop_start  = (s_data.operation == OP_POP);
                                cmd.dump_start = (s_data.operation == OP_DUMP);
                                state_next     = S_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.load_data = 1'b1;
                    if (sts.emit_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/dss_dpath.sv =====
// datapath: shared memory, stack counts, read pointer and result register
module dss_dpath
    import dss_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  in_t  s_data,
    input  cmd_t cmd,
    output sts_t sts,
    input  logic m_ready,
    output logic m_valid,
    output out_t m_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] TOP_C   = CW'(DEPTH - 1);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [DATA_WIDTH-1:0] wdata;
    logic [31:0]           elem;

    logic [CW-1:0] lower_cnt_reg, upper_cnt_reg;
    logic [CW-1:0] rem_reg, rem_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic          sel_reg, sel_next;
    logic          m_valid_reg;
    out_t          m_data_reg;

    logic [CW:0]   used;
    logic [AW-1:0] push_addr, start_addr, step_addr, rd_addr;
    logic          start, advance, rd_en;

    generate
        if (DATA_WIDTH >= 32) begin : g_wide
            assign wdata = {{(DATA_WIDTH - 32 + 1){s_data.push_value[31]}},
                            s_data.push_value[30:0]};
            assign elem  = rdata_reg[31:0];
        end else begin : g_narrow
            assign wdata = s_data.push_value[DATA_WIDTH-1:0];
            assign elem  = {{(32 - DATA_WIDTH){1'b0}}, rdata_reg};
        end
    endgenerate

    assign used = {1'b0, lower_cnt_reg} + {1'b0, upper_cnt_reg};

    assign sts.full        = (used >= DEPTH_S);
    assign sts.lower_empty = (lower_cnt_reg == '0);
    assign sts.upper_empty = (upper_cnt_reg == '0);
    assign sts.out_free    = !m_valid_reg || m_ready;
    assign sts.emit_last   = (rem_reg == ONE_C);

    assign push_addr  = s_data.which_stack ? AW'(TOP_C - upper_cnt_reg)
                                           : AW'(lower_cnt_reg);
    assign start_addr = s_data.which_stack ? AW'(DEPTH_C - upper_cnt_reg)
                                           : AW'(lower_cnt_reg - ONE_C);
    assign step_addr  = sel_reg ? AW'(ptr_reg + AW'(1)) : AW'(ptr_reg - AW'(1));

    assign start   = cmd.pop_start || cmd.dump_start;
    assign advance = cmd.load_data && !sts.emit_last;
    assign rd_en   = start || advance;
    assign rd_addr = start ? start_addr : step_addr;

    always_comb begin
        ptr_next = ptr_reg;
        rem_next = rem_reg;
        sel_next = sel_reg;
        if (start) begin
            ptr_next = start_addr;
            sel_next = s_data.which_stack;
            if (cmd.pop_start) begin
                rem_next = ONE_C;
            end else begin
                rem_next = s_data.which_stack ? upper_cnt_reg : lower_cnt_reg;
            end
        end else if (advance) begin
            ptr_next = step_addr;
            rem_next = rem_reg - ONE_C;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_wr) begin
            mem[push_addr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_cnt_reg <= '0;
            upper_cnt_reg <= '0;
            rem_reg       <= '0;
            ptr_reg       <= '0;
            sel_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            rem_reg <= rem_next;
            ptr_reg <= ptr_next;
            sel_reg <= sel_next;
            if (cmd.push_wr) begin
                if (s_data.which_stack) begin
                    upper_cnt_reg <= upper_cnt_reg + ONE_C;
                end else begin
                    lower_cnt_reg <= lower_cnt_reg + ONE_C;
                end
            end else if (cmd.pop_start) begin
                if (s_data.which_stack) begin
                    upper_cnt_reg <= upper_cnt_reg - ONE_C;
                end else begin
                    lower_cnt_reg <= lower_cnt_reg - ONE_C;
                end
            end
            if (cmd.load_stat || cmd.load_data) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_stat) begin
            m_data_reg.status  <= cmd.stat;
            m_data_reg.element <= '0;
            m_data_reg.last    <= 1'b1;
        end else if (cmd.load_data) begin
            m_data_reg.status  <= STAT_OK;
            m_data_reg.element <= elem;
            m_data_reg.last    <= sts.emit_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        used <= DEPTH_S)
        else $error("stack counts exceed memory depth");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push_wr |-> !sts.full)
        else $error("push written into full memory");

    a_emit_has_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_data |-> (rem_reg != '0))
        else $error("element emitted with no remaining count");

    a_out_not_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !(cmd.load_stat || cmd.load_data))
        else $error("result register overwritten while stalled");
`endif

endmodule
